### hdl/rpsi_pkg.sv
`timescale 1ns / 1ps

package rpsi_pkg;

    // Fixed field widths of the stream payload.
    localparam int FIELD_W = 32;
    localparam int EPS_W = 16;

    // Default coordinate width; widths above the field width act as the field width.
    localparam int COORD_WIDTH_DEF = 32;

    // Reset value of the tolerance register.
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Result classification.
    typedef enum logic [1:0] {
        KIND_MISS  = 2'd0,
        KIND_POINT = 2'd1,
        KIND_CROSS = 2'd2,
        KIND_COLIN = 2'd3
    } kind_t;

    // Result data that rides alongside the dividers.
    typedef struct packed {
        kind_t               kind;
        logic [FIELD_W-1:0]  hx;
        logic [FIELD_W-1:0]  hy;
        logic [FIELD_W-1:0]  ox;
        logic [FIELD_W-1:0]  oy;
    } side_t;

endpackage

### hdl/rpsi_fdiv.sv
`timescale 1ns / 1ps

// Pipelined floor divider: quo = floor(num / den) for den > 0, clamped to
// +/- 2**QUO_BITS. One quotient bit is resolved per register stage.
module rpsi_fdiv #(
    parameter int NUM_W = 100,
    parameter int DEN_W = 67,
    parameter int QUO_BITS = 33
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]          den,
    output logic signed [QUO_BITS+1:0] quo
);

    localparam int RW = DEN_W + QUO_BITS;
    localparam int EXW = ((NUM_W > RW) ? NUM_W : RW) + 1;
    localparam int QW = QUO_BITS + 2;

    logic [NUM_W-1:0] mag;
    logic [EXW-1:0]   mag_ext;
    logic             big_next;

    logic [RW-1:0]       rem_reg [0:QUO_BITS];
    logic [DEN_W-1:0]    den_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg   [0:QUO_BITS];
    logic                neg_reg [0:QUO_BITS];
    logic                big_reg [0:QUO_BITS];

    // Magnitude of the dividend and the out-of-range check.
    assign mag = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
    assign mag_ext = EXW'(mag);
    assign big_next = mag_ext >= (EXW'(den) << QUO_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= mag_ext[RW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1];
            big_reg[0] <= big_next;
        end
    end

    // Restoring division, most significant quotient bit first.
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int SH = QUO_BITS - 1 - k;
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = RW'(den_reg[k]) << SH;
        assign ge = rem_reg[k] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? (rem_reg[k] - trial) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][QUO_BITS-2:0], ge};
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    // Floor correction for negative dividends and the clamp.
    logic [QW-1:0] qm;
    logic [QW-1:0] lim;
    logic          rnz;

    assign rnz = rem_reg[QUO_BITS] != '0;
    assign qm = QW'(q_reg[QUO_BITS]) + QW'(neg_reg[QUO_BITS] & rnz);
    assign lim = QW'(1) << QUO_BITS;

    always_comb begin
        if (big_reg[QUO_BITS]) begin
            quo = neg_reg[QUO_BITS] ? $signed(-lim) : $signed(lim);
        end else begin
            quo = neg_reg[QUO_BITS] ? $signed(-qm) : $signed(qm);
        end
    end

endmodule

### hdl/ray_point_segment_intersect.sv
`timescale 1ns / 1ps

// Ray against point or segment test in 2D signed fixed point. Each request
// carries a ray and a point (tuser 0) or a segment (tuser 1) and yields one
// result with a hit flag, a hit kind and the hit point. The block takes one
// request per clock while the output is not stalled. The pipe is built of
// seven arithmetic stages, two bit-per-stage floor dividers of COORD_WIDTH + 2
// registers for the rounded crossing point (COORD_WIDTH capped at 32), and
// the output register. The whole pipe advances when the output register is
// empty or being taken, so a stall holds every stage in place. The tolerance
// is written on the cfg channel and must only be changed while no request is
// in flight.
module ray_point_segment_intersect #(
    parameter int COORD_WIDTH = rpsi_pkg::COORD_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Tolerance register write.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    // Requests.
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, dir_x, dir_y, first_x, first_y, second_x, second_y
    input  logic [255:0] s_tdata,
    // action
    input  logic [0:0]   s_tuser,
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_x, hit_y
    output logic [63:0]  m_tdata,
    // hit, hit_kind[1:0]
    output logic [2:0]   m_tuser
);

    localparam int FW = rpsi_pkg::FIELD_W;
    localparam int W  = (COORD_WIDTH > FW) ? FW : COORD_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 3;
    localparam int EW = W + rpsi_pkg::EPS_W;
    localparam int HW = W + 1;
    localparam int MW = HW + W;
    localparam int PTW = HW + MW;
    localparam int NW = 3 * W + 4;
    localparam int QB = W + 1;
    localparam int QW = QB + 2;

    typedef struct packed {
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic signed [W-1:0] bx;
        logic signed [W-1:0] by;
    } pts_t;

    logic adv;
    logic [rpsi_pkg::EPS_W-1:0] eps_reg;

    // The pipe moves as one when the output slot is empty or being taken.
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign cfg_ready = 1'b1;

    // Tolerance register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= rpsi_pkg::EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    // Stage 1: capture the request, keeping the low coordinate-width bits of each field as signed values.
    logic                v1_reg;
    logic                act1_reg;
    logic signed [W-1:0] dx1_reg, dy1_reg;
    pts_t                pts1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            act1_reg    <= s_tuser[0];
            pts1_reg.ox <= $signed(s_tdata[W-1:0]);
            pts1_reg.oy <= $signed(s_tdata[32+W-1:32]);
            dx1_reg     <= $signed(s_tdata[64+W-1:64]);
            dy1_reg     <= $signed(s_tdata[96+W-1:96]);
            pts1_reg.ax <= $signed(s_tdata[128+W-1:128]);
            pts1_reg.ay <= $signed(s_tdata[160+W-1:160]);
            pts1_reg.bx <= $signed(s_tdata[192+W-1:192]);
            pts1_reg.by <= $signed(s_tdata[224+W-1:224]);
        end
    end

    // Stage 2: coordinate differences and the point-mode decision.
    logic                v2_reg;
    logic                pm2_reg;
    logic signed [W-1:0] dx2_reg, dy2_reg;
    logic signed [W:0]   sx2_reg, sy2_reg, qx2_reg, qy2_reg, rx2_reg, ry2_reg;
    pts_t                pts2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pm2_reg  <= !act1_reg ||
                        (pts1_reg.ax == pts1_reg.bx && pts1_reg.ay == pts1_reg.by);
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            sx2_reg  <= (W+1)'(pts1_reg.bx) - (W+1)'(pts1_reg.ax);
            sy2_reg  <= (W+1)'(pts1_reg.by) - (W+1)'(pts1_reg.ay);
            qx2_reg  <= (W+1)'(pts1_reg.ax) - (W+1)'(pts1_reg.ox);
            qy2_reg  <= (W+1)'(pts1_reg.ay) - (W+1)'(pts1_reg.oy);
            rx2_reg  <= (W+1)'(pts1_reg.bx) - (W+1)'(pts1_reg.ox);
            ry2_reg  <= (W+1)'(pts1_reg.by) - (W+1)'(pts1_reg.oy);
            pts2_reg <= pts1_reg;
        end
    end

    // Stage 3: all cross and dot product terms, plus the narrow point tests.
    logic [W-1:0] adx2, ady2;
    logic [W:0]   aqx2, aqy2;
    logic         dx_pos2, dy_pos2, qx_pos2, qy_pos2;

    assign adx2 = dx2_reg[W-1] ? $unsigned(-dx2_reg) : $unsigned(dx2_reg);
    assign ady2 = dy2_reg[W-1] ? $unsigned(-dy2_reg) : $unsigned(dy2_reg);
    assign aqx2 = qx2_reg[W] ? $unsigned(-qx2_reg) : $unsigned(qx2_reg);
    assign aqy2 = qy2_reg[W] ? $unsigned(-qy2_reg) : $unsigned(qy2_reg);
    assign dx_pos2 = !dx2_reg[W-1] && dx2_reg != '0;
    assign dy_pos2 = !dy2_reg[W-1] && dy2_reg != '0;
    assign qx_pos2 = !qx2_reg[W] && qx2_reg != '0;
    assign qy_pos2 = !qy2_reg[W] && qy2_reg != '0;

    logic                 v3_reg;
    logic                 pm3_reg, bmiss3_reg, vert3_reg, horiz3_reg, vhit3_reg, hhit3_reg;
    logic                 dirnz3_reg, dxneg3_reg, dyneg3_reg;
    logic [W-1:0]         adx3_reg, ady3_reg;
    logic [EW-1:0]        epsadx3_reg;
    logic signed [PW-1:0] m_dxsy_reg, m_dysx_reg, m_qxdy_reg, m_qydx_reg, m_qxsy_reg;
    logic signed [PW-1:0] m_qysx_reg, m_qxdx_reg, m_qydy_reg, m_rxdx_reg, m_rydy_reg;
    pts_t                 pts3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pm3_reg     <= pm2_reg;
            // Point behind the origin on either axis.
            bmiss3_reg  <= (dy2_reg[W-1] ? qy_pos2 : qy2_reg[W]) ||
                           (dx2_reg[W-1] ? qx_pos2 : qx2_reg[W]);
            vert3_reg   <= adx2 < W'(eps_reg);
            horiz3_reg  <= ady2 < W'(eps_reg);
            vhit3_reg   <= (aqx2 < (W+1)'(eps_reg)) &&
                           (dy_pos2 ? qy_pos2 : qy2_reg[W]);
            hhit3_reg   <= (aqy2 < (W+1)'(eps_reg)) &&
                           (dx_pos2 ? qx_pos2 : qx2_reg[W]);
            dirnz3_reg  <= dx2_reg != '0 || dy2_reg != '0;
            dxneg3_reg  <= dx2_reg[W-1];
            dyneg3_reg  <= dy2_reg[W-1];
            adx3_reg    <= adx2;
            ady3_reg    <= ady2;
            epsadx3_reg <= EW'(eps_reg) * EW'(adx2);
            m_dxsy_reg  <= PW'(dx2_reg) * PW'(sy2_reg);
            m_dysx_reg  <= PW'(dy2_reg) * PW'(sx2_reg);
            m_qxdy_reg  <= PW'(qx2_reg) * PW'(dy2_reg);
            m_qydx_reg  <= PW'(qy2_reg) * PW'(dx2_reg);
            m_qxsy_reg  <= PW'(qx2_reg) * PW'(sy2_reg);
            m_qysx_reg  <= PW'(qy2_reg) * PW'(sx2_reg);
            m_qxdx_reg  <= PW'(qx2_reg) * PW'(dx2_reg);
            m_qydy_reg  <= PW'(qy2_reg) * PW'(dy2_reg);
            m_rxdx_reg  <= PW'(rx2_reg) * PW'(dx2_reg);
            m_rydy_reg  <= PW'(ry2_reg) * PW'(dy2_reg);
            pts3_reg    <= pts2_reg;
        end
    end

    // Stage 4: cross products and endpoint projections.
    logic                 v4_reg;
    logic                 pm4_reg, bmiss4_reg, vert4_reg, horiz4_reg, vhit4_reg, hhit4_reg;
    logic                 dirnz4_reg, dxneg4_reg, dyneg4_reg;
    logic [W-1:0]         adx4_reg, ady4_reg;
    logic [EW-1:0]        epsadx4_reg;
    logic signed [SW-1:0] rxs4_reg, qxr4_reg, tn4_reg, p04_reg, p14_reg;
    pts_t                 pts4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pm4_reg     <= pm3_reg;
            bmiss4_reg  <= bmiss3_reg;
            vert4_reg   <= vert3_reg;
            horiz4_reg  <= horiz3_reg;
            vhit4_reg   <= vhit3_reg;
            hhit4_reg   <= hhit3_reg;
            dirnz4_reg  <= dirnz3_reg;
            dxneg4_reg  <= dxneg3_reg;
            dyneg4_reg  <= dyneg3_reg;
            adx4_reg    <= adx3_reg;
            ady4_reg    <= ady3_reg;
            epsadx4_reg <= epsadx3_reg;
            rxs4_reg    <= SW'(m_dxsy_reg) - SW'(m_dysx_reg);
            qxr4_reg    <= SW'(m_qxdy_reg) - SW'(m_qydx_reg);
            tn4_reg     <= SW'(m_qxsy_reg) - SW'(m_qysx_reg);
            p04_reg     <= SW'(m_qxdx_reg) + SW'(m_qydy_reg);
            p14_reg     <= SW'(m_rxdx_reg) + SW'(m_rydy_reg);
            pts4_reg    <= pts3_reg;
        end
    end

    // Stage 5: point verdict, colinear ordering, and sign normalization of
    // the crossing terms so the denominator is positive.
    logic [SW-1:0] aqxr4;
    logic          gen_hit4, near4, flip4;

    assign aqxr4 = qxr4_reg[SW-1] ? $unsigned(-qxr4_reg) : $unsigned(qxr4_reg);
    assign gen_hit4 = aqxr4 < SW'(epsadx4_reg);
    assign near4 = p04_reg < p14_reg;
    assign flip4 = rxs4_reg[SW-1];

    logic                 v5_reg;
    logic                 pm5_reg, pthit5_reg, rxz5_reg, colin5_reg, near5_reg;
    logic                 dxneg5_reg, dyneg5_reg;
    logic [W-1:0]         adx5_reg, ady5_reg;
    logic signed [SW-1:0] pmin5_reg, pmax5_reg, tn5_reg, un5_reg, den5_reg;
    pts_t                 pts5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pm5_reg    <= pm4_reg;
            pthit5_reg <= !bmiss4_reg &&
                          (vert4_reg ? vhit4_reg : (horiz4_reg ? hhit4_reg : gen_hit4));
            rxz5_reg   <= rxs4_reg == '0;
            colin5_reg <= rxs4_reg == '0 && qxr4_reg == '0 && dirnz4_reg;
            near5_reg  <= near4;
            pmin5_reg  <= near4 ? p04_reg : p14_reg;
            pmax5_reg  <= near4 ? p14_reg : p04_reg;
            tn5_reg    <= flip4 ? -tn4_reg : tn4_reg;
            un5_reg    <= flip4 ? -qxr4_reg : qxr4_reg;
            den5_reg   <= flip4 ? -rxs4_reg : rxs4_reg;
            dxneg5_reg <= dxneg4_reg;
            dyneg5_reg <= dyneg4_reg;
            adx5_reg   <= adx4_reg;
            ady5_reg   <= ady4_reg;
            pts5_reg   <= pts4_reg;
        end
    end

    // Stage 6: result kind and non-crossing hit point; partial products of
    // t * |d| for the crossing point.
    rpsi_pkg::side_t side6_next;

    always_comb begin
        side6_next.kind = rpsi_pkg::KIND_MISS;
        side6_next.hx = '0;
        side6_next.hy = '0;
        side6_next.ox = FW'(pts5_reg.ox);
        side6_next.oy = FW'(pts5_reg.oy);
        if (pm5_reg) begin
            if (pthit5_reg) begin
                side6_next.kind = rpsi_pkg::KIND_POINT;
                side6_next.hx = FW'(pts5_reg.ax);
                side6_next.hy = FW'(pts5_reg.ay);
            end
        end else if (rxz5_reg) begin
            if (colin5_reg && !pmax5_reg[SW-1]) begin
                side6_next.kind = rpsi_pkg::KIND_COLIN;
                if (pmin5_reg[SW-1] || pmin5_reg == '0) begin
                    side6_next.hx = FW'(pts5_reg.ox);
                    side6_next.hy = FW'(pts5_reg.oy);
                end else if (near5_reg) begin
                    side6_next.hx = FW'(pts5_reg.ax);
                    side6_next.hy = FW'(pts5_reg.ay);
                end else begin
                    side6_next.hx = FW'(pts5_reg.bx);
                    side6_next.hy = FW'(pts5_reg.by);
                end
            end
        end else if (!tn5_reg[SW-1] && !un5_reg[SW-1] && !(den5_reg < un5_reg)) begin
            side6_next.kind = rpsi_pkg::KIND_CROSS;
        end
    end

    logic                 v6_reg;
    rpsi_pkg::side_t      side6_reg;
    logic                 dxneg6_reg, dyneg6_reg;
    logic [MW-1:0]        ppxl6_reg, ppxh6_reg, ppyl6_reg, ppyh6_reg;
    logic signed [SW-1:0] den6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side6_reg  <= side6_next;
            dxneg6_reg <= dxneg5_reg;
            dyneg6_reg <= dyneg5_reg;
            den6_reg   <= den5_reg;
            ppxl6_reg  <= MW'(tn5_reg[HW-1:0]) * MW'(adx5_reg);
            ppxh6_reg  <= MW'(tn5_reg[2*HW-1:HW]) * MW'(adx5_reg);
            ppyl6_reg  <= MW'(tn5_reg[HW-1:0]) * MW'(ady5_reg);
            ppyh6_reg  <= MW'(tn5_reg[2*HW-1:HW]) * MW'(ady5_reg);
        end
    end

    // Stage 7: rounding numerators 2*t*d + den and the divisor 2*den.
    logic [PTW-1:0]       px6, py6;
    logic signed [NW-1:0] twopx6, twopy6, den_ext6;

    assign px6 = (PTW'(ppxh6_reg) << HW) + PTW'(ppxl6_reg);
    assign py6 = (PTW'(ppyh6_reg) << HW) + PTW'(ppyl6_reg);
    assign twopx6 = $signed(NW'({px6, 1'b0}));
    assign twopy6 = $signed(NW'({py6, 1'b0}));
    assign den_ext6 = NW'(den6_reg);

    logic                 v7_reg;
    rpsi_pkg::side_t      side7_reg;
    logic signed [NW-1:0] nx7_reg, ny7_reg;
    logic [SW-1:0]        d7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (adv) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side7_reg <= side6_reg;
            nx7_reg   <= den_ext6 + (dxneg6_reg ? -twopx6 : twopx6);
            ny7_reg   <= den_ext6 + (dyneg6_reg ? -twopy6 : twopy6);
            d7_reg    <= {den6_reg[SW-2:0], 1'b0};
        end
    end

    // Floor dividers for the rounded crossing offsets.
    logic signed [QW-1:0] qx_div, qy_div;

    rpsi_fdiv #(
        .NUM_W    (NW),
        .DEN_W    (SW),
        .QUO_BITS (QB)
    ) u_div_x (
        .aclk (aclk),
        .en   (adv),
        .num  (nx7_reg),
        .den  (d7_reg),
        .quo  (qx_div)
    );

    rpsi_fdiv #(
        .NUM_W    (NW),
        .DEN_W    (SW),
        .QUO_BITS (QB)
    ) u_div_y (
        .aclk (aclk),
        .en   (adv),
        .num  (ny7_reg),
        .den  (d7_reg),
        .quo  (qy_div)
    );

    // Side data delay line matched to the divider latency.
    logic            dv_reg   [0:QB];
    rpsi_pkg::side_t side_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side7_reg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Output stage: add the origin, saturate, and select the hit point.
    function automatic logic [W-1:0] sat_w(input logic [W+3:0] s);
        logic [W-1:0] r;
        if (s[W+3:W-1] == {5{s[W+3]}}) begin
            r = s[W-1:0];
        end else if (s[W+3]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    rpsi_pkg::side_t      side_q;
    logic signed [W-1:0]  oxw, oyw, hxs, hys;
    logic signed [W+3:0]  sumx, sumy;
    logic [FW-1:0]        hx_next, hy_next;

    assign side_q = side_reg[QB];
    assign oxw = $signed(side_q.ox[W-1:0]);
    assign oyw = $signed(side_q.oy[W-1:0]);
    assign sumx = (W+4)'(oxw) + (W+4)'(qx_div);
    assign sumy = (W+4)'(oyw) + (W+4)'(qy_div);
    assign hxs = $signed(sat_w(sumx));
    assign hys = $signed(sat_w(sumy));

    always_comb begin
        if (side_q.kind == rpsi_pkg::KIND_CROSS) begin
            hx_next = FW'(hxs);
            hy_next = FW'(hys);
        end else begin
            hx_next = side_q.hx;
            hy_next = side_q.hy;
        end
    end

    logic          out_valid_reg;
    logic [63:0]   out_data_reg;
    logic [2:0]    out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {hy_next, hx_next};
            out_user_reg <= {side_q.kind, side_q.kind != rpsi_pkg::KIND_MISS};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule
